### rtl/ddtw_pkg.sv
`default_nettype none
package ddtw_pkg;

  // Command codes of the input item.
  localparam logic [2:0] CMD_SET_TWIST   = 3'd0;
  localparam logic [2:0] CMD_TICK        = 3'd1;
  localparam logic [2:0] CMD_START_ALIGN = 3'd2;
  localparam logic [2:0] CMD_START_CALIB = 3'd3;
  localparam logic [2:0] CMD_ABORT       = 3'd4;

  // Routine phases, also used as wheel start codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ALIGN_R = 3'd1;
  localparam logic [2:0] PH_ALIGN_L = 3'd2;
  localparam logic [2:0] PH_CAL_R   = 3'd3;
  localparam logic [2:0] PH_CAL_L   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_INV_RADIUS  = 3'd0;
  localparam logic [2:0] REG_HALF_TRACK  = 3'd1;
  localparam logic [2:0] REG_LIN_LIMIT   = 3'd2;
  localparam logic [2:0] REG_ANG_LIMIT   = 3'd3;
  localparam logic [2:0] REG_LIN_ACCEL   = 3'd4;
  localparam logic [2:0] REG_ANG_ACCEL   = 3'd5;
  localparam logic [2:0] REG_WHEEL_LIMIT = 3'd6;
  localparam logic [2:0] REG_MODE        = 3'd7;

  // Reciprocal radius after reset (1.0) and when the register holds zero (1000.0).
  localparam logic [30:0] INV_R_RESET   = 31'd65536;
  localparam logic [30:0] INV_R_DEFAULT = 31'd65536000;

  // Width of the shared divider.
  localparam int DIV_W = 64;
  localparam int DIV_CW = $clog2(DIV_W);

endpackage
`default_nettype wire

### rtl/ddtw_ifs.sv
`default_nettype none
interface ddtw_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] linear_target;
  logic signed [31:0] angular_target;
  logic [15:0]        tick_seconds;
  logic [7:0]         lap_count;
  logic signed [31:0] assist_rate;
  logic               right_pattern_ready;
  logic               left_pattern_ready;
  logic               right_busy;
  logic               left_busy;

  modport source (
    output valid, command, linear_target, angular_target, tick_seconds, lap_count,
           assist_rate, right_pattern_ready, left_pattern_ready, right_busy, left_busy,
    input  ready
  );
  modport sink (
    input  valid, command, linear_target, angular_target, tick_seconds, lap_count,
           assist_rate, right_pattern_ready, left_pattern_ready, right_busy, left_busy,
    output ready
  );
endinterface

interface ddtw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] right_wheel_rate;
  logic signed [31:0] left_wheel_rate;
  logic signed [31:0] linear_command;
  logic signed [31:0] angular_command;
  logic [2:0]         phase;
  logic [2:0]         wheel_start;
  logic [7:0]         laps_out;
  logic               accepted;

  modport source (
    output valid, right_wheel_rate, left_wheel_rate, linear_command, angular_command,
           phase, wheel_start, laps_out, accepted,
    input  ready
  );
  modport sink (
    input  valid, right_wheel_rate, left_wheel_rate, linear_command, angular_command,
           phase, wheel_start, laps_out, accepted,
    output ready
  );
endinterface
`default_nettype wire

### rtl/ddtw_div.sv
`default_nettype none
module ddtw_div
  import ddtw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DIV_W-1:0] - dsr_r : trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a running division");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("divider did not start");
`endif

endmodule
`default_nettype wire

### rtl/diff_drive_twist_to_wheel_rates.sv
`default_nettype none
// Differential-drive twist to wheel-rate converter with align/calibrate sequencing.
// Input channel in_item carries one command per item: set twist, tick, start align,
// start calibrate or abort. Every item yields exactly one result on out_item: the
// wheel rates last handed to the wheels, the ramped linear and angular commands,
// the routine phase, a wheel start code with its lap count, and a start-accepted flag.
// The block works on one item at a time under a small sequencer around one shared
// 32x32 multiplier and a bit-serial divider; in_item.ready is high only when idle.
// Non-tick commands pass through decode straight to the output state. A tick runs two
// slew products, then three two-part Q16.16 products for the wheel rates. A tick that
// triggers wheel-rate rescaling adds two divisions plus a second wheel-rate pass.
// Results are held in an output register; while it still holds an undelivered result,
// the block waits with the finished one and takes no new item until it is loaded.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once and are
// made while the block is idle: a rule for the user that the block does not enforce.
// Synchronous reset clears all but the work and output payload registers: rates and
// commands zero, routine idle, reciprocal radius 1.0, all limits and modes zero.
module diff_drive_twist_to_wheel_rates
  import ddtw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  ddtw_in_if.sink          in_item,
  ddtw_out_if.source       out_item,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DEC      = 11'b000_0000_0010,
    S_SLEW_MUL = 11'b000_0000_0100,
    S_SLEW_UPD = 11'b000_0000_1000,
    S_Q_HI     = 11'b000_0001_0000,
    S_Q_LO     = 11'b000_0010_0000,
    S_Q_FIN    = 11'b000_0100_0000,
    S_WCHK     = 11'b000_1000_0000,
    S_SCL_MUL  = 11'b001_0000_0000,
    S_SCL_DIV  = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  // Saturate a 32-bit value to +/- an unsigned 31-bit bound.
  function automatic logic signed [31:0] clamp_b(input logic signed [31:0] x,
                                                 input logic [30:0] b);
    logic signed [32:0] lim;
    logic signed [32:0] xe;
    lim = {2'b00, b};
    xe  = {x[31], x};
    if (xe > lim) return {1'b0, b};
    else if (xe < -lim) return 32'(-lim);
    else return x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    else if (x < -64'sd2147483648) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

  // Configuration registers.
  logic [30:0] inv_r_r, half_track_r, lin_lim_r, ang_lim_r;
  logic [30:0] lin_acc_r, ang_acc_r, wheel_lim_r;
  logic [63:0] mode_r;

  // Latched input item.
  logic [2:0]         cmd_r;
  logic signed [31:0] lin_tgt_r, ang_tgt_r, assist_r;
  logic [15:0]        dt_r;
  logic [7:0]         laps_in_r;
  logic               rpat_r, lpat_r, rbusy_r, lbusy_r;

  // Architectural state.
  logic signed [31:0] lin_ref_r, lin_ref_nxt, ang_ref_r, ang_ref_nxt;
  logic signed [31:0] lin_cur_r, lin_cur_nxt, ang_cur_r, ang_cur_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [7:0]         laps_r, laps_nxt;
  logic [31:0]        spin_r, spin_nxt;
  logic signed [31:0] held_r_r, held_r_nxt, held_l_r, held_l_nxt;

  // Sequencer and work registers.
  state_t             state_r, state_nxt;
  logic               sel_r, sel_nxt;
  logic [1:0]         qidx_r, qidx_nxt;
  logic signed [48:0] qa_r, qa_nxt;
  logic signed [63:0] hw_r, hw_nxt, wr_r, wr_nxt, wl_r, wl_nxt;
  logic [63:0]        prod_r, phi_r, phi_nxt, amax_r, amax_nxt;
  logic               routine_tick_r, routine_tick_nxt;
  logic               rescaled_r, rescaled_nxt;
  logic               div_go_r, div_go_nxt;
  logic [2:0]         start_r, start_nxt;
  logic               acc_r, acc_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] o_wr_r, o_wl_r, o_lin_r, o_ang_r;
  logic [2:0]         o_phase_r, o_start_r;
  logic [7:0]         o_laps_r;
  logic               o_acc_r;
  logic               out_load;

  // Shared datapath signals.
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [30:0]        ir_eff, q_b;
  logic [48:0]        qmag;
  logic [63:0]        qres_u;
  logic signed [63:0] qres;
  logic [63:0]        mag_wr, mag_wl, amax;
  logic signed [31:0] sl_cur, sl_ref, sl_new;
  logic [30:0]        sl_acc, sl_lim;
  logic signed [33:0] sl_d, sl_dmax;
  logic signed [31:0] sc_x, sc_q;
  logic [31:0]        sc_mag;
  logic [30:0]        dflt;
  logic               div_busy, div_done;
  logic [DIV_W-1:0]   div_q;

  assign in_item.ready = (state_r == S_IDLE);

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r_r      <= INV_R_RESET;
      half_track_r <= '0;
      lin_lim_r    <= '0;
      ang_lim_r    <= '0;
      lin_acc_r    <= '0;
      ang_acc_r    <= '0;
      wheel_lim_r  <= '0;
      mode_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_RADIUS:  inv_r_r      <= cfg_data[30:0];
        REG_HALF_TRACK:  half_track_r <= cfg_data[30:0];
        REG_LIN_LIMIT:   lin_lim_r    <= cfg_data[30:0];
        REG_ANG_LIMIT:   ang_lim_r    <= cfg_data[30:0];
        REG_LIN_ACCEL:   lin_acc_r    <= cfg_data[30:0];
        REG_ANG_ACCEL:   ang_acc_r    <= cfg_data[30:0];
        REG_WHEEL_LIMIT: wheel_lim_r  <= cfg_data[30:0];
        REG_MODE:        mode_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection.
  assign ir_eff = (inv_r_r == '0) ? INV_R_DEFAULT : inv_r_r;
  assign q_b    = (qidx_r == 2'd0) ? half_track_r : ir_eff;
  assign qmag   = qa_r[48] ? 49'(-qa_r) : qa_r;
  assign sc_x   = sel_r ? ang_cur_r : lin_cur_r;
  assign sc_mag = sc_x[31] ? 32'(-sc_x) : sc_x;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SLEW_MUL: begin
        mul_a = {1'b0, sel_r ? ang_acc_r : lin_acc_r};
        mul_b = {16'd0, dt_r};
      end
      S_Q_HI: begin
        mul_a = qmag[47:16];
        mul_b = {1'b0, q_b};
      end
      S_Q_LO: begin
        mul_a = {16'd0, qmag[15:0]};
        mul_b = {1'b0, q_b};
      end
      S_SCL_MUL: begin
        mul_a = sc_mag;
        mul_b = {1'b0, wheel_lim_r};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // Q16.16 product combine: high part plus low part shifted down, sign restored.
  assign qres_u = phi_r + (prod_r >> 16);
  assign qres   = qa_r[48] ? -$signed(qres_u) : $signed(qres_u);

  // Slew toward the reference by at most accel*dt unless accel is 0; optional clamp.
  assign sl_cur  = sel_r ? ang_cur_r : lin_cur_r;
  assign sl_ref  = sel_r ? ang_ref_r : lin_ref_r;
  assign sl_acc  = sel_r ? ang_acc_r : lin_acc_r;
  assign sl_lim  = sel_r ? ang_lim_r : lin_lim_r;
  assign sl_d    = 34'(sl_ref) - 34'(sl_cur);
  assign sl_dmax = {2'b00, prod_r[47:16]};

  always_comb begin
    logic signed [31:0] s;
    if (sl_acc == '0) s = sl_ref;
    else if (sl_d > sl_dmax) s = sl_cur + prod_r[47:16];
    else if (sl_d < -sl_dmax) s = sl_cur - prod_r[47:16];
    else s = sl_ref;
    sl_new = mode_r[0] ? clamp_b(s, sl_lim) : s;
  end

  // Largest wheel rate magnitude for the rescale check.
  assign mag_wr = wr_r[63] ? 64'(-wr_r) : wr_r;
  assign mag_wl = wl_r[63] ? 64'(-wl_r) : wl_r;
  assign amax   = (mag_wr > mag_wl) ? mag_wr : mag_wl;
  assign sc_q   = sc_x[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);

  assign dflt = (in_item.command == CMD_START_ALIGN) ? mode_r[32:2] : mode_r[63:33];

  ddtw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (prod_r),
    .divisor  (amax_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_item.ready);

  // Sequencer.
  always_comb begin
    lin_ref_nxt      = lin_ref_r;
    ang_ref_nxt      = ang_ref_r;
    lin_cur_nxt      = lin_cur_r;
    ang_cur_nxt      = ang_cur_r;
    phase_nxt        = phase_r;
    laps_nxt         = laps_r;
    spin_nxt         = spin_r;
    held_r_nxt       = held_r_r;
    held_l_nxt       = held_l_r;
    state_nxt        = state_r;
    sel_nxt          = sel_r;
    qidx_nxt         = qidx_r;
    qa_nxt           = qa_r;
    hw_nxt           = hw_r;
    wr_nxt           = wr_r;
    wl_nxt           = wl_r;
    phi_nxt          = phi_r;
    amax_nxt         = amax_r;
    routine_tick_nxt = routine_tick_r;
    rescaled_nxt     = rescaled_r;
    div_go_nxt       = 1'b0;
    start_nxt        = start_r;
    acc_nxt          = acc_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          start_nxt = PH_IDLE;
          acc_nxt   = 1'b0;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_SET_TWIST: begin
            if (phase_r == PH_IDLE) begin
              lin_ref_nxt = mode_r[0] ? clamp_b(lin_tgt_r, lin_lim_r) : lin_tgt_r;
              ang_ref_nxt = mode_r[0] ? clamp_b(ang_tgt_r, ang_lim_r) : ang_tgt_r;
            end
          end
          CMD_TICK: begin
            routine_tick_nxt = (phase_r != PH_IDLE);
            if (phase_r != PH_IDLE) begin
              lin_ref_nxt = '0;
              ang_ref_nxt = (phase_r == PH_ALIGN_R || phase_r == PH_CAL_R) ?
                            $signed(spin_r) : -$signed(spin_r);
            end
            rescaled_nxt = 1'b0;
            sel_nxt      = 1'b0;
            state_nxt    = S_SLEW_MUL;
          end
          CMD_START_ALIGN, CMD_START_CALIB: begin
            if (phase_r == PH_IDLE && laps_in_r != '0) begin
              logic [2:0] st;
              st = PH_IDLE;
              if (cmd_r == CMD_START_CALIB) st = PH_CAL_R;
              else if (rpat_r) st = PH_ALIGN_R;
              else if (lpat_r) st = PH_ALIGN_L;
              start_nxt = st;
              if (st != PH_IDLE) begin
                phase_nxt = st;
                laps_nxt  = laps_in_r;
                spin_nxt  = (assist_r > 0) ? assist_r :
                            {1'b0, (cmd_r == CMD_START_ALIGN) ? mode_r[32:2] : mode_r[63:33]};
                acc_nxt   = 1'b1;
              end
            end
          end
          CMD_ABORT: begin
            if (phase_r != PH_IDLE) begin
              phase_nxt   = PH_IDLE;
              laps_nxt    = '0;
              spin_nxt    = '0;
              lin_ref_nxt = '0;
              ang_ref_nxt = '0;
              lin_cur_nxt = '0;
              ang_cur_nxt = '0;
              held_r_nxt  = '0;
              held_l_nxt  = '0;
            end
          end
          default: ;
        endcase
      end

      S_SLEW_MUL: state_nxt = S_SLEW_UPD;

      S_SLEW_UPD: begin
        if (sel_r) begin
          ang_cur_nxt = sl_new;
          qidx_nxt    = 2'd0;
          qa_nxt      = 49'(ang_cur_nxt);
          state_nxt   = S_Q_HI;
        end else begin
          lin_cur_nxt = sl_new;
          sel_nxt     = 1'b1;
          state_nxt   = S_SLEW_MUL;
        end
      end

      S_Q_HI: state_nxt = S_Q_LO;

      S_Q_LO: begin
        phi_nxt   = prod_r;
        state_nxt = S_Q_FIN;
      end

      S_Q_FIN: begin
        unique case (qidx_r)
          2'd0: begin
            hw_nxt    = qres;
            qa_nxt    = 49'(lin_cur_r) + qres[48:0];
            qidx_nxt  = 2'd1;
            state_nxt = S_Q_HI;
          end
          2'd1: begin
            wr_nxt    = qres;
            qa_nxt    = 49'(lin_cur_r) - hw_r[48:0];
            qidx_nxt  = 2'd2;
            state_nxt = S_Q_HI;
          end
          default: begin
            wl_nxt    = qres;
            state_nxt = S_WCHK;
          end
        endcase
      end

      S_WCHK: begin
        state_nxt = S_OUT;
        if (!routine_tick_r && !rescaled_r && wheel_lim_r != '0 && mode_r[1] &&
            amax > {33'd0, wheel_lim_r}) begin
          amax_nxt  = amax;
          sel_nxt   = 1'b0;
          state_nxt = S_SCL_MUL;
        end else begin
          held_r_nxt = sat32(wr_r);
          held_l_nxt = sat32(wl_r);
          if (routine_tick_r) begin
            logic leave;
            leave = 1'b0;
            case (phase_r)
              PH_ALIGN_R: begin
                if (!rbusy_r) begin
                  if (lpat_r) begin
                    phase_nxt = PH_ALIGN_L;
                    start_nxt = PH_ALIGN_L;
                  end else begin
                    leave = 1'b1;
                  end
                end
              end
              PH_ALIGN_L: leave = !lbusy_r;
              PH_CAL_R: begin
                if (!rbusy_r) begin
                  phase_nxt = PH_CAL_L;
                  start_nxt = PH_CAL_L;
                end
              end
              default: leave = !lbusy_r;
            endcase
            if (leave) begin
              phase_nxt   = PH_IDLE;
              laps_nxt    = '0;
              spin_nxt    = '0;
              lin_ref_nxt = '0;
              ang_ref_nxt = '0;
              lin_cur_nxt = '0;
              ang_cur_nxt = '0;
              held_r_nxt  = '0;
              held_l_nxt  = '0;
            end
          end
        end
      end

      S_SCL_MUL: begin
        div_go_nxt = 1'b1;
        state_nxt  = S_SCL_DIV;
      end

      S_SCL_DIV: begin
        if (div_done) begin
          if (sel_r) begin
            ang_cur_nxt  = sc_q;
            rescaled_nxt = 1'b1;
            qidx_nxt     = 2'd0;
            qa_nxt       = 49'(sc_q);
            state_nxt    = S_Q_HI;
          end else begin
            lin_cur_nxt = sc_q;
            sel_nxt     = 1'b1;
            state_nxt   = S_SCL_MUL;
          end
        end
      end

      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_item.ready ? 1'b0 : out_valid_r);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      lin_ref_r      <= '0;
      ang_ref_r      <= '0;
      lin_cur_r      <= '0;
      ang_cur_r      <= '0;
      phase_r        <= PH_IDLE;
      laps_r         <= '0;
      spin_r         <= '0;
      held_r_r       <= '0;
      held_l_r       <= '0;
      div_go_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      routine_tick_r <= 1'b0;
      rescaled_r     <= 1'b0;
      sel_r          <= 1'b0;
      qidx_r         <= '0;
      start_r        <= PH_IDLE;
      acc_r          <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      lin_ref_r      <= lin_ref_nxt;
      ang_ref_r      <= ang_ref_nxt;
      lin_cur_r      <= lin_cur_nxt;
      ang_cur_r      <= ang_cur_nxt;
      phase_r        <= phase_nxt;
      laps_r         <= laps_nxt;
      spin_r         <= spin_nxt;
      held_r_r       <= held_r_nxt;
      held_l_r       <= held_l_nxt;
      div_go_r       <= div_go_nxt;
      out_valid_r    <= out_valid_nxt;
      routine_tick_r <= routine_tick_nxt;
      rescaled_r     <= rescaled_nxt;
      sel_r          <= sel_nxt;
      qidx_r         <= qidx_nxt;
      start_r        <= start_nxt;
      acc_r          <= acc_nxt;
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk) begin
    qa_r   <= qa_nxt;
    hw_r   <= hw_nxt;
    wr_r   <= wr_nxt;
    wl_r   <= wl_nxt;
    phi_r  <= phi_nxt;
    amax_r <= amax_nxt;
    if (state_r == S_IDLE && in_item.valid) begin
      cmd_r     <= in_item.command;
      lin_tgt_r <= in_item.linear_target;
      ang_tgt_r <= in_item.angular_target;
      dt_r      <= in_item.tick_seconds;
      laps_in_r <= in_item.lap_count;
      assist_r  <= (in_item.assist_rate > 0) ? in_item.assist_rate : {1'b0, dflt};
      rpat_r    <= in_item.right_pattern_ready;
      lpat_r    <= in_item.left_pattern_ready;
      rbusy_r   <= in_item.right_busy;
      lbusy_r   <= in_item.left_busy;
    end
    if (out_load) begin
      o_wr_r    <= held_r_r;
      o_wl_r    <= held_l_r;
      o_lin_r   <= lin_cur_r;
      o_ang_r   <= ang_cur_r;
      o_phase_r <= phase_r;
      o_start_r <= start_r;
      o_laps_r  <= (start_r != PH_IDLE) ? laps_r : 8'd0;
      o_acc_r   <= acc_r;
    end
  end

  assign out_item.valid            = out_valid_r;
  assign out_item.right_wheel_rate = o_wr_r;
  assign out_item.left_wheel_rate  = o_wl_r;
  assign out_item.linear_command   = o_lin_r;
  assign out_item.angular_command  = o_ang_r;
  assign out_item.phase            = o_phase_r;
  assign out_item.wheel_start      = o_start_r;
  assign out_item.laps_out         = o_laps_r;
  assign out_item.accepted         = o_acc_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.valid && in_item.ready |=> state_r == S_DEC)
    else $error("accepted item did not enter decode");
  a_acc_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.accepted |-> out_item.wheel_start != PH_IDLE)
    else $error("accepted start without wheel start code");
  a_laps_need_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.wheel_start == PH_IDLE |-> out_item.laps_out == 8'd0)
    else $error("lap count reported without wheel start");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> laps_r == 8'd0 || acc_r)
    else $error("idle routine holds laps");
  a_div_only_rescale: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_SCL_DIV)
    else $error("divider running outside rescale");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ddtw_pkg::*;

  localparam int IDLE_PCT = 32;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS_PER_SET = 155;

  typedef struct {
    logic [2:0]  cmd;
    int          lin;
    int          ang;
    logic [15:0] dt;
    logic [7:0]  laps;
    int          assist;
    logic        rpat;
    logic        lpat;
    logic        rbusy;
    logic        lbusy;
  } cmd_item_t;

  typedef struct {
    int         right_rate;
    int         left_rate;
    int         lin_cmd;
    int         ang_cmd;
    logic [2:0] ph;
    logic [2:0] start;
    logic [7:0] laps;
    logic       acc;
  } rate_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  ddtw_in_if in_ch();
  ddtw_out_if out_ch();

  diff_drive_twist_to_wheel_rates DUT (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch), .out_item(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Pending items and the wheel-rate results they should produce.
  cmd_item_t pending_cmds[$];
  rate_result_t expected_rates[$];
  cmd_item_t on_bus;
  int mismatches = 0;
  int results_seen = 0;
  int idle_pct = IDLE_PCT;
  int hold_left = 0;
  int stall_cycles = 0;
  bit hold_done = 0;

  // Shadow of the configuration registers.
  longint unsigned c_inv, c_half, c_lin_lim, c_ang_lim, c_lin_acc, c_ang_acc, c_wheel_lim;
  logic [63:0] c_mode;

  // Shadow of the block state.
  int lin_tgt, ang_tgt, lin_cur, ang_cur, held_r, held_l;
  logic [2:0] cur_phase;
  logic [7:0] cur_laps;
  logic [31:0] cur_spin;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned magn(longint a);
    return a < 0 ? longint'(0) - a : a;
  endfunction

  // Signed value times unsigned Q16.16, truncated toward zero.
  function automatic longint mul_q(longint a, longint unsigned b);
    longint unsigned m, r;
    m = magn(a);
    r = (m >> 16) * b + (((m & 64'hFFFF) * b) >> 16);
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic int sat_32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFFFFFF;
    if (x < -64'sd2147483648) return 32'h80000000;
    return int'(x);
  endfunction

  function automatic int clamp_to(int x, longint unsigned b);
    longint lim;
    lim = longint'(b);
    if (longint'(x) > lim) return int'(lim);
    if (longint'(x) < -lim) return int'(-lim);
    return x;
  endfunction

  function automatic int slew_to(int cur, int tgt, longint unsigned accel, longint unsigned dt);
    longint dmax, d;
    if (accel == 0) return tgt;
    dmax = longint'((accel * dt) >> 16);
    d = longint'(tgt) - longint'(cur);
    if (d > dmax) return int'(longint'(cur) + dmax);
    if (d < -dmax) return int'(longint'(cur) - dmax);
    return tgt;
  endfunction

  function automatic void wheel_rates(int v, int w, output longint r, output longint l);
    longint unsigned ir;
    longint hw;
    ir = (c_inv != 0) ? c_inv : longint'(INV_R_DEFAULT);
    hw = mul_q(w, c_half);
    r = mul_q(longint'(v) + hw, ir);
    l = mul_q(longint'(v) - hw, ir);
  endfunction

  function automatic int shrink(int x, longint unsigned lim, longint unsigned amax);
    longint unsigned q;
    q = magn(x) * lim / amax;
    return x < 0 ? int'(-longint'(q)) : int'(q);
  endfunction

  function automatic void ramp_rates(longint unsigned dt);
    lin_cur = slew_to(lin_cur, lin_tgt, c_lin_acc, dt);
    ang_cur = slew_to(ang_cur, ang_tgt, c_ang_acc, dt);
    if (c_mode[0]) begin
      lin_cur = clamp_to(lin_cur, c_lin_lim);
      ang_cur = clamp_to(ang_cur, c_ang_lim);
    end
  endfunction

  function automatic void end_routine();
    cur_phase = PH_IDLE;
    cur_laps = 0;
    cur_spin = 0;
    lin_tgt = 0; ang_tgt = 0; lin_cur = 0; ang_cur = 0;
    held_r = 0; held_l = 0;
  endfunction

  // Advance the shadow state by one item and return the expected result.
  function automatic rate_result_t predict_rates(cmd_item_t it);
    rate_result_t res;
    logic [2:0] start;
    logic acc;
    longint wr, wl;
    longint unsigned ar, al, amax, dflt;
    logic [31:0] s;
    start = PH_IDLE;
    acc = 0;
    case (it.cmd)
      CMD_SET_TWIST: begin
        if (cur_phase == PH_IDLE) begin
          lin_tgt = it.lin;
          ang_tgt = it.ang;
          if (c_mode[0]) begin
            lin_tgt = clamp_to(lin_tgt, c_lin_lim);
            ang_tgt = clamp_to(ang_tgt, c_ang_lim);
          end
        end
      end
      CMD_TICK: begin
        if (cur_phase != PH_IDLE) begin
          lin_tgt = 0;
          ang_tgt = (cur_phase == PH_ALIGN_R || cur_phase == PH_CAL_R) ?
                    int'(cur_spin) : -int'(cur_spin);
          ramp_rates(it.dt);
          wheel_rates(lin_cur, ang_cur, wr, wl);
          held_r = sat_32(wr);
          held_l = sat_32(wl);
          case (cur_phase)
            PH_ALIGN_R: begin
              if (!it.rbusy) begin
                if (it.lpat) begin
                  cur_phase = PH_ALIGN_L;
                  start = PH_ALIGN_L;
                end else begin
                  end_routine();
                end
              end
            end
            PH_CAL_R: begin
              if (!it.rbusy) begin
                cur_phase = PH_CAL_L;
                start = PH_CAL_L;
              end
            end
            default: begin
              if (!it.lbusy) end_routine();
            end
          endcase
        end else begin
          ramp_rates(it.dt);
          wheel_rates(lin_cur, ang_cur, wr, wl);
          if (c_wheel_lim > 0 && c_mode[1]) begin
            ar = magn(wr);
            al = magn(wl);
            amax = ar > al ? ar : al;
            if (amax > c_wheel_lim) begin
              lin_cur = shrink(lin_cur, c_wheel_lim, amax);
              ang_cur = shrink(ang_cur, c_wheel_lim, amax);
              wheel_rates(lin_cur, ang_cur, wr, wl);
            end
          end
          held_r = sat_32(wr);
          held_l = sat_32(wl);
        end
      end
      CMD_START_ALIGN, CMD_START_CALIB: begin
        if (cur_phase == PH_IDLE && it.laps != 0) begin
          dflt = (it.cmd == CMD_START_ALIGN) ? c_mode[32:2] : c_mode[63:33];
          s = it.assist > 0 ? it.assist : dflt[31:0];
          if (it.cmd == CMD_START_CALIB) start = PH_CAL_R;
          else if (it.rpat) start = PH_ALIGN_R;
          else if (it.lpat) start = PH_ALIGN_L;
          if (start != PH_IDLE) begin
            cur_phase = start;
            cur_laps = it.laps;
            cur_spin = s;
            acc = 1;
          end
        end
      end
      CMD_ABORT: begin
        if (cur_phase != PH_IDLE) end_routine();
      end
      default: ;
    endcase
    res.right_rate = held_r;
    res.left_rate = held_l;
    res.lin_cmd = lin_cur;
    res.ang_cmd = ang_cur;
    res.ph = cur_phase;
    res.start = start;
    res.laps = (start != PH_IDLE) ? cur_laps : 8'd0;
    res.acc = acc;
    return res;
  endfunction

  // Input driver: predict on acceptance, then offer the next pending item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_rates.push_back(predict_rates(on_bus));
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        on_bus = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= on_bus.cmd;
        in_ch.linear_target <= on_bus.lin;
        in_ch.angular_target <= on_bus.ang;
        in_ch.tick_seconds <= on_bus.dt;
        in_ch.lap_count <= on_bus.laps;
        in_ch.assist_rate <= on_bus.assist;
        in_ch.right_pattern_ready <= on_bus.rpat;
        in_ch.left_pattern_ready <= on_bus.lpat;
        in_ch.right_busy <= on_bus.rbusy;
        in_ch.left_busy <= on_bus.lbusy;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor, receiver stalls and the watchdog.
  always @(posedge clk) begin
    rate_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_rates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result with no item pending at %0t", $realtime);
        end else begin
          exp_r = expected_rates.pop_front();
          if (out_ch.right_wheel_rate !== exp_r.right_rate ||
              out_ch.left_wheel_rate !== exp_r.left_rate ||
              out_ch.linear_command !== exp_r.lin_cmd ||
              out_ch.angular_command !== exp_r.ang_cmd ||
              out_ch.phase !== exp_r.ph || out_ch.wheel_start !== exp_r.start ||
              out_ch.laps_out !== exp_r.laps || out_ch.accepted !== exp_r.acc) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at %0t: expected r=%0d l=%0d v=%0d w=%0d ph=%0d st=%0d n=%0d a=%0d, got r=%0d l=%0d v=%0d w=%0d ph=%0d st=%0d n=%0d a=%0d",
                $realtime, exp_r.right_rate, exp_r.left_rate, exp_r.lin_cmd,
                exp_r.ang_cmd, exp_r.ph, exp_r.start, exp_r.laps, exp_r.acc,
                out_ch.right_wheel_rate, out_ch.left_wheel_rate, out_ch.linear_command,
                out_ch.angular_command, out_ch.phase, out_ch.wheel_start,
                out_ch.laps_out, out_ch.accepted);
          end
        end
      end
      // One long hold-off partway through so the block backs up.
      if (!hold_done && results_seen == 400) begin
        hold_done <= 1'b1;
        hold_left <= 500;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(99) >= idle_pct;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic add_cmd(logic [2:0] cmd, int lin, int ang, logic [15:0] dt,
                         logic [7:0] laps, int assist, logic [3:0] flags);
    cmd_item_t it;
    it.cmd = cmd; it.lin = lin; it.ang = ang; it.dt = dt;
    it.laps = laps; it.assist = assist;
    {it.rpat, it.lpat, it.rbusy, it.lbusy} = flags;
    pending_cmds.push_back(it);
  endtask

  function automatic int rand_rate();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h7FFFFFFF, 32'h7FFFFFF0);
      2: return -int'($urandom_range(32'h0008_0000));
      3: return 32'h80000000;
      default: return $urandom_range(32'h0008_0000);
    endcase
  endfunction

  function automatic logic [63:0] rand_reg(int extreme);
    if (extreme == 1) return 64'h7FFFFFFF;
    if (extreme == 2) return 64'd0;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return $urandom_range(32'h0000_4000);
      default: return $urandom_range(32'h0010_0000);
    endcase
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INV_RADIUS:  c_inv = data[30:0];
      REG_HALF_TRACK:  c_half = data[30:0];
      REG_LIN_LIMIT:   c_lin_lim = data[30:0];
      REG_ANG_LIMIT:   c_ang_lim = data[30:0];
      REG_LIN_ACCEL:   c_lin_acc = data[30:0];
      REG_ANG_ACCEL:   c_ang_acc = data[30:0];
      REG_WHEEL_LIMIT: c_wheel_lim = data[30:0];
      default:         c_mode = data;
    endcase
  endtask

  // Sender pause: wait until every expected result is back and the block is quiet.
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_rates.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic, mostly twist/tick runs and align or calibrate starts followed by ticks.
  task automatic add_random(int count);
    int n;
    logic [2:0] cmd;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 20) begin
        cmd = $urandom_range(1) ? CMD_START_ALIGN : CMD_START_CALIB;
        add_cmd(cmd, rand_rate(), rand_rate(), 16'($urandom),
                ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom),
                $urandom_range(1) ? rand_rate() : int'($urandom_range(32'h40000)),
                4'($urandom));
        n++;
        repeat ($urandom_range(6, 1)) begin
          add_cmd(($urandom_range(19) == 0) ? CMD_ABORT : CMD_TICK, rand_rate(),
                  rand_rate(), 16'($urandom), 8'($urandom), rand_rate(),
                  {1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(99) < 60), 1'($urandom_range(99) < 60)});
          n++;
        end
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4: cmd = CMD_SET_TWIST;
          5:             cmd = CMD_ABORT;
          6:             cmd = 3'($urandom_range(7, 5));
          default:       cmd = CMD_TICK;
        endcase
        add_cmd(cmd, rand_rate(), rand_rate(), 16'($urandom), 8'($urandom), rand_rate(),
                4'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_INV_RADIUS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_SET_TWIST;
    in_ch.linear_target = 0;
    in_ch.angular_target = 0;
    in_ch.tick_seconds = 0;
    in_ch.lap_count = 0;
    in_ch.assist_rate = 0;
    in_ch.right_pattern_ready = 1'b0;
    in_ch.left_pattern_ready = 1'b0;
    in_ch.right_busy = 1'b0;
    in_ch.left_busy = 1'b0;
    out_ch.ready = 1'b0;
    c_inv = INV_R_RESET;
    c_half = 0; c_lin_lim = 0; c_ang_lim = 0;
    c_lin_acc = 0; c_ang_acc = 0; c_wheel_lim = 0; c_mode = '0;
    end_routine();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under a small ramped, clamped and rescaled setting.
    cfg_write(REG_INV_RADIUS, 64'h0002_0000);
    cfg_write(REG_HALF_TRACK, 64'h0000_8000);
    cfg_write(REG_LIN_LIMIT, 64'h0003_0000);
    cfg_write(REG_ANG_LIMIT, 64'h0002_0000);
    cfg_write(REG_LIN_ACCEL, 64'h0010_0000);
    cfg_write(REG_ANG_ACCEL, 64'h0008_0000);
    cfg_write(REG_WHEEL_LIMIT, 64'h0004_0000);
    cfg_write(REG_MODE, {31'h0001_0000, 31'h0000_8000, 2'b11});
    idle_pct = 0;
    add_cmd(CMD_SET_TWIST, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 4'h0);
    add_cmd(CMD_TICK, 0, 0, 16'd0, 0, 0, 4'h0);
    add_cmd(CMD_TICK, 0, 0, 16'hFFFF, 0, 0, 4'h0);
    add_cmd(CMD_TICK, 0, 0, 16'hFFFF, 0, 0, 4'h0);
    add_cmd(CMD_START_ALIGN, 0, 0, 0, 8'd0, 0, 4'b1100);
    add_cmd(CMD_START_ALIGN, 0, 0, 0, 8'd3, 0, 4'b0000);
    add_cmd(CMD_ABORT, 0, 0, 0, 0, 0, 4'h0);
    add_cmd(CMD_START_ALIGN, 0, 0, 0, 8'hFF, 32'h80000000, 4'b1100);
    add_cmd(CMD_START_CALIB, 0, 0, 0, 8'd2, 0, 4'h0);
    add_cmd(CMD_SET_TWIST, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 4'h0);
    add_cmd(CMD_TICK, 0, 0, 16'h1000, 0, 0, 4'b0011);
    add_cmd(CMD_TICK, 0, 0, 16'h1000, 0, 0, 4'b0100);
    add_cmd(CMD_TICK, 0, 0, 16'h1000, 0, 0, 4'b0001);
    add_cmd(CMD_TICK, 0, 0, 16'h1000, 0, 0, 4'b0000);
    add_cmd(CMD_START_ALIGN, 0, 0, 0, 8'd1, 32'h0000_4000, 4'b1000);
    add_cmd(CMD_TICK, 0, 0, 16'h8000, 0, 0, 4'b0000);
    add_cmd(CMD_START_ALIGN, 0, 0, 0, 8'd4, 0, 4'b0100);
    add_cmd(CMD_TICK, 0, 0, 16'h8000, 0, 0, 4'b0000);
    add_cmd(CMD_START_CALIB, 0, 0, 0, 8'd5, 32'h7FFFFFFF, 4'h0);
    add_cmd(CMD_TICK, 0, 0, 16'hFFFF, 0, 0, 4'b0001);
    add_cmd(CMD_TICK, 0, 0, 16'hFFFF, 0, 0, 4'b0010);
    add_cmd(CMD_TICK, 0, 0, 16'hFFFF, 0, 0, 4'b0000);
    add_cmd(3'd7, 0, 0, 0, 0, 0, 4'hF);
    add_cmd(CMD_START_CALIB, 0, 0, 0, 8'd1, 0, 4'h0);
    add_cmd(CMD_ABORT, 0, 0, 0, 0, 0, 4'h0);
    drain();

    // Random phases under the directed settings, extremes, zeros and random settings.
    for (int set_no = 0; set_no < 8; set_no++) begin
      if (set_no > 0) begin
        for (int r = 0; r < 8; r++)
          cfg_write(3'(r), (r == REG_MODE && set_no == 1) ? 64'hFFFF_FFFF_FFFF_FFFF :
                    rand_reg(set_no <= 2 ? set_no : 0));
      end
      // Set 4 runs without idle gaps; the other sets leave random gaps.
      idle_pct = (set_no == 4) ? 0 : IDLE_PCT;
      add_random(ITEMS_PER_SET);
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ddtw_pkg.sv
rtl/ddtw_ifs.sv
rtl/ddtw_div.sv
rtl/diff_drive_twist_to_wheel_rates.sv
tb/tb_top.sv
